FILE: hw/rtl/integer_to_radix_string_defines.svh
// ----------------------------------------------------------------------------
// integer_to_radix_string assertion macros
// Shared property wrappers for the radix conversion block.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_STRING_DEFINES_SVH
`define INTEGER_TO_RADIX_STRING_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ITRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itrs assertion failed");

// next-cycle implication, disabled in reset
`define ITRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itrs assertion failed");

`endif

FILE: hw/rtl/itrs_pkg.sv
// ----------------------------------------------------------------------------
// itrs_pkg
// Types, character codes and helpers for the radix string converter.
// ----------------------------------------------------------------------------
package itrs_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // digit value 0..35 to ascii
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d8;
    d8 = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < DECIMAL) begin
      digit_char = CHAR_ZERO + d8;
    end else begin
      digit_char = CHAR_A + d8 - {{(CHAR_W-RADIX_W){1'b0}}, DECIMAL};
    end
  endfunction

endpackage

FILE: hw/rtl/itrs_divider.sv
// ----------------------------------------------------------------------------
// itrs_divider
// Restoring divider, one quotient bit per cycle, small radix divisor.
// ----------------------------------------------------------------------------
module itrs_divider
  import itrs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [RADIX_W-1:0]     remainder,
  output div_stat_t              stat
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo_r;
  logic [RADIX_W-1:0]     rem_r;
  logic [RADIX_W-1:0]     div_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [RADIX_W:0] trial;
  logic [RADIX_W:0] diff;
  logic             geq;

  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign geq   = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(VALUE_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VALUE_WIDTH-2:0], geq};
      rem_r <= geq ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

endmodule

FILE: hw/rtl/integer_to_radix_string.sv
// Digits come from the bit-serial divider, least significant first; then a leading
// minus for a negative decimal value, then each digit is read back from the
// digit store (ST_FETCH) and sent (ST_SEND). Zero and bad-radix requests give
// a single character straight from idle, with out_error set for a bad radix.
// One request at a time, taken only in idle while the output is not stalled.
// Synchronous active-low reset returns to idle with no result pending.
// ----------------------------------------------------------------------------
// integer_to_radix_string
// Converts an integer to ascii digits in base 2..36, msd first (signed in base 10 only).
// ----------------------------------------------------------------------------
`include "integer_to_radix_string_defines.svh"

module integer_to_radix_string
  import itrs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic [RADIX_W-1:0]            in_radix,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CHAR_W-1:0]             out_character,
  output logic                          out_last,
  output logic                          out_error
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic               minus_r, minus_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_error_r, out_error_nxt;

  logic [RADIX_W-1:0] digit_mem [VALUE_WIDTH];
  logic [RADIX_W-1:0] rd_digit_r;
  logic               wr_en;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_W-1:0]     div_divisor;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [RADIX_W-1:0]     div_rem;
  div_stat_t              div_stat;

  logic                   in_stall_c;
  logic                   in_acc;
  logic                   out_free;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] value_u;
  logic [VALUE_WIDTH-1:0] mag;

  itrs_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .remainder(div_rem),
    .stat     (div_stat)
  );

  assign value_u  = $unsigned(in_value);
  assign neg      = (in_radix == DECIMAL) && value_u[VALUE_WIDTH-1];
  assign mag      = neg ? (~value_u + 1'b1) : value_u;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall_c = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall_c;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    radix_nxt     = radix_r;
    minus_nxt     = minus_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_error_nxt = out_error_r;
    wr_en         = 1'b0;
    div_start     = 1'b0;
    div_dividend  = mag;
    div_divisor   = in_radix;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if ((in_radix < RADIX_MIN) || (in_radix > RADIX_MAX)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_NUL;
            out_last_nxt  = 1'b1;
            out_error_nxt = 1'b1;
          end else if (value_u == '0) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_ZERO;
            out_last_nxt  = 1'b1;
            out_error_nxt = 1'b0;
          end else begin
            radix_nxt = in_radix;
            minus_nxt = neg;
            cnt_nxt   = '0;
            div_start = 1'b1;
            state_nxt = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        div_divisor  = radix_r;
        div_dividend = div_quotient;
        if (div_stat.done) begin
          wr_en = 1'b1;
          if (div_quotient == '0) begin
            // cnt_r now points at the most significant digit
            state_nxt = minus_r ? ST_SIGN : ST_FETCH;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            div_start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          out_error_nxt = 1'b0;
          state_nxt     = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(rd_digit_r);
          out_last_nxt  = (cnt_r == '0);
          out_error_nxt = 1'b0;
          if (cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      minus_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      minus_r     <= minus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r     <= radix_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_error_r <= out_error_nxt;
  end

  // digit store, least significant digit at address zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[cnt_r[AW-1:0]] <= div_rem;
    end
    rd_digit_r <= digit_mem[cnt_r[AW-1:0]];
  end

  assign in_stall      = in_stall_c;
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_error     = out_error_r;

  `ITRS_ASSERT_NOW(a_err_char_nul, clk, rst_n, out_valid_r && out_error_r,
                   (out_char_r == CHAR_NUL) && out_last_r)
  `ITRS_ASSERT_NOW(a_done_in_divide, clk, rst_n, div_stat.done, state_r == ST_DIVIDE)
  `ITRS_ASSERT_NEXT(a_accept_progress, clk, rst_n, in_acc,
                    (state_r != ST_IDLE) || out_valid_r)
  `ITRS_ASSERT_NOW(a_send_index, clk, rst_n, state_r == ST_SEND,
                   cnt_r < CW'(VALUE_WIDTH))

endmodule
